// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, inactive while reset is asserted
`define LBPC_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define LBPC_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/lbpc_pkg.sv =====
`default_nettype none

package lbpc_pkg;

	localparam int LED_COUNT_DEF  = 13;
	localparam int PWM_PERIOD_DEF = 20;
	localparam int RATE_W         = 10;
	localparam int PIN_W          = 13;

	// command codes carried on s_tuser
	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_ON     = 3'd1,
		OP_OFF    = 3'd2,
		OP_TOGGLE = 3'd3,
		OP_BLINK  = 3'd4,
		OP_PWM    = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_BLINK  = 2'd1,
		MODE_PWM    = 2'd2
	} led_mode_t;

	// one memory word per LED
	typedef struct packed {
		logic              duty;
		logic [RATE_W-1:0] cnt;
		logic [RATE_W-1:0] rate;
		led_mode_t         mode;
	} led_entry_t;

	localparam led_entry_t ENTRY_RESET = '{
		duty: 1'b1,
		cnt:  '0,
		rate: '0,
		mode: MODE_NORMAL
	};

	// command as seen by the update logic
	typedef struct packed {
		op_t               op;
		logic [RATE_W-1:0] rate;
	} cmd_t;

endpackage

`default_nettype wire

// ===== src/lbpc_ram.sv =====
`default_nettype none

module lbpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/lbpc_update.sv =====
`default_nettype none

module lbpc_update #(
	parameter int PWM_PERIOD = lbpc_pkg::PWM_PERIOD_DEF
) (
	input  wire lbpc_pkg::cmd_t       cmd,
	input  wire lbpc_pkg::led_entry_t cur,
	input  wire logic                 lit_cur,
	output lbpc_pkg::led_entry_t      nxt,
	output logic                      lit_nxt
);

	localparam logic [lbpc_pkg::RATE_W-1:0] PERIOD = PWM_PERIOD[lbpc_pkg::RATE_W-1:0];

	logic [lbpc_pkg::RATE_W-1:0] cnt_dec;
	logic [lbpc_pkg::RATE_W-1:0] pwm_rate;

	assign cnt_dec  = cur.cnt - 1'b1;
	// pwm rate saturates at the period
	assign pwm_rate = (cmd.rate > PERIOD) ? PERIOD : cmd.rate;

	always_comb begin
		nxt     = cur;
		lit_nxt = lit_cur;
		case (cmd.op)
			lbpc_pkg::OP_TICK: begin
				case (cur.mode)
					lbpc_pkg::MODE_PWM: begin
						if (cur.rate == '0) begin
							lit_nxt = 1'b0;
						end else if (cur.rate >= PERIOD) begin
							lit_nxt = 1'b1;
						end else begin
							nxt.cnt = cnt_dec;
							if (cnt_dec == '0) begin
								// phase flip
								if (cur.duty) begin
									lit_nxt  = 1'b0;
									nxt.cnt  = PERIOD - cur.rate;
									nxt.duty = 1'b0;
								end else begin
									lit_nxt  = 1'b1;
									nxt.cnt  = cur.rate;
									nxt.duty = 1'b1;
								end
							end
						end
					end
					lbpc_pkg::MODE_BLINK: begin
						nxt.cnt = cnt_dec;
						if (cnt_dec == '0) begin
							lit_nxt = ~lit_cur;
							nxt.cnt = cur.rate;
						end
					end
					default: begin
					end
				endcase
			end
			lbpc_pkg::OP_ON: begin
				lit_nxt  = 1'b1;
				nxt.mode = lbpc_pkg::MODE_NORMAL;
			end
			lbpc_pkg::OP_OFF: begin
				lit_nxt  = 1'b0;
				nxt.mode = lbpc_pkg::MODE_NORMAL;
			end
			lbpc_pkg::OP_TOGGLE: begin
				lit_nxt = ~lit_cur;
			end
			lbpc_pkg::OP_BLINK: begin
				nxt.mode = lbpc_pkg::MODE_BLINK;
				nxt.rate = cmd.rate;
				nxt.cnt  = cmd.rate;
			end
			lbpc_pkg::OP_PWM: begin
				nxt.mode = lbpc_pkg::MODE_PWM;
				nxt.rate = pwm_rate;
				nxt.cnt  = pwm_rate;
				nxt.duty = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/led_blink_pwm_controller.sv =====
// LED blink / soft-PWM controller.
// Input channel (s_t*): one item is a command. s_tuser holds the code (tick, on,
// off, toggle, start blink, start pwm), s_tdata the LED index and a rate.
// Output channel (m_t*): every item, tick or command, returns one item with the
// pin levels: the lit flags XOR the active-low mask from the APB register.
// Per-LED mode, rate, counter and phase live in a small synchronous RAM; lit
// flags stay in flops so the pin word is available at once.
// A tick reads and writes back every LED entry, one per cycle, while a command
// touches one entry and an ignored command (bad index or code) touches none.
// One item is in flight at a time; s_tready is high only when idle. A finished
// result waits in the output register, and the next item may be accepted while
// it is stalled; a second result waits until the first has been taken.
// Reset clears the mask, all lit flags and the entry valid bits, so every LED
// starts in normal mode, off, high PWM phase; no clearing pass is needed.
`default_nettype none

module led_blink_pwm_controller #(
	parameter int LED_COUNT  = lbpc_pkg::LED_COUNT_DEF,
	parameter int PWM_PERIOD = lbpc_pkg::PWM_PERIOD_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [3:0] led_index, [13:4] rate, zero fill
	input  wire logic [2:0]  s_tuser,  // [2:0] command code
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata   // [12:0] pin_levels, zero fill
);

	localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int ENT_W = $bits(lbpc_pkg::led_entry_t);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_WB   = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;

	logic [lbpc_pkg::PIN_W-1:0]  mask_q;
	logic [LED_COUNT-1:0]        lit_q;
	logic [LED_COUNT-1:0]        vld_q;
	logic [IDX_W-1:0]            ptr_q;
	lbpc_pkg::op_t               op_q;
	logic [lbpc_pkg::RATE_W-1:0] rate_q;

	logic                        rd_v_s1;
	logic                        vld_s1;
	logic [IDX_W-1:0]            addr_s1;

	logic                        m_tvalid_q;
	logic [lbpc_pkg::PIN_W-1:0]  out_q;

	logic                        in_acc;
	logic                        cfg_wr;
	lbpc_pkg::op_t               in_op;
	logic [3:0]                  in_idx;
	logic                        in_work;
	logic                        run_last;
	logic                        out_free;

	logic [ENT_W-1:0]            ram_rdata;
	lbpc_pkg::led_entry_t        ent_cur;
	lbpc_pkg::led_entry_t        ent_nxt;
	lbpc_pkg::cmd_t              cmd;
	logic                        lit_cur;
	logic                        lit_nxt;
	logic [lbpc_pkg::PIN_W-1:0]  pins;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == 1'b0) ? {{(32 - lbpc_pkg::PIN_W){1'b0}}, mask_q} : '0;

	// input decode
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid & s_tready;
	assign in_op    = lbpc_pkg::op_t'(s_tuser);
	assign in_idx   = s_tdata[3:0];
	// tick, or a known command on an existing LED
	assign in_work  = (in_op == lbpc_pkg::OP_TICK) ||
		((in_op <= lbpc_pkg::OP_PWM) && ({1'b0, in_idx} < 5'(LED_COUNT)));

	assign run_last = (op_q != lbpc_pkg::OP_TICK) || (ptr_q == LAST_IDX);
	assign out_free = ~m_tvalid_q | m_tready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_RUN);
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= in_work ? ST_RUN : ST_DONE;
					end
				end
				ST_RUN: begin
					if (run_last) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item fields and read pointer
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= in_op;
			rate_q <= s_tdata[13:4];
			ptr_q  <= (in_op == lbpc_pkg::OP_TICK) ? '0 : in_idx[IDX_W-1:0];
		end else if (state_q == ST_RUN && !run_last) begin
			ptr_q <= ptr_q + 1'b1;
		end
		addr_s1 <= ptr_q;
		vld_s1  <= vld_q[ptr_q];
	end

	// entry store
	lbpc_ram #(
		.WIDTH(ENT_W),
		.DEPTH(LED_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (rd_v_s1),
		.waddr(addr_s1),
		.wdata(ent_nxt),
		.re   (state_q == ST_RUN),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	// never-written entries read as reset value
	assign ent_cur  = vld_s1 ? lbpc_pkg::led_entry_t'(ram_rdata) : lbpc_pkg::ENTRY_RESET;
	assign lit_cur  = lit_q[addr_s1];
	assign cmd.op   = op_q;
	assign cmd.rate = rate_q;

	lbpc_update #(
		.PWM_PERIOD(PWM_PERIOD)
	) u_update (
		.cmd    (cmd),
		.cur    (ent_cur),
		.lit_cur(lit_cur),
		.nxt    (ent_nxt),
		.lit_nxt(lit_nxt)
	);

	// lit flags, valid bits, mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q  <= '0;
			vld_q  <= '0;
			mask_q <= '0;
		end else begin
			if (rd_v_s1) begin
				lit_q[addr_s1] <= lit_nxt;
				vld_q[addr_s1] <= 1'b1;
			end
			if (cfg_wr && paddr[2] == 1'b0) begin
				mask_q <= pwdata[lbpc_pkg::PIN_W-1:0];
			end
		end
	end

	// pin word: lit flags above the LED count read as zero
	for (genvar i = 0; i < lbpc_pkg::PIN_W; i++) begin : g_pin
		if (i < LED_COUNT) begin : g_led
			assign pins[i] = lit_q[i] ^ mask_q[i];
		end else begin : g_nc
			assign pins[i] = mask_q[i];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q <= pins;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(16 - lbpc_pkg::PIN_W){1'b0}}, out_q};

endmodule

`default_nettype wire

// ===== src/lbpc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module lbpc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [2:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata,
	input wire logic        pready,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	logic mask_wr;
	logic in_acc;

	assign mask_wr = psel & penable & pwrite & pready & (paddr[2] == 1'b0);
	assign in_acc  = s_tvalid & s_tready;

	// no result is shown once reset has been seen at a clock edge
	`LBPC_ASSERT_ALWAYS(a_no_out_in_reset, clk, !arst_n |=> !m_tvalid, "m_tvalid during reset")

	// one item at a time: taking an item closes the input for the next cycle
	`LBPC_ASSERT(a_one_in_flight, clk, arst_n, in_acc |=> !s_tready, "second item taken early")

	// a mask write reads back on the next cycle
	`LBPC_ASSERT(a_mask_readback, clk, arst_n,
		mask_wr ##1 (paddr[2] == 1'b0) |-> prdata[12:0] == $past(pwdata[12:0]),
		"mask readback mismatch")

	// a stalled result holds
	`LBPC_ASSERT(a_out_hold, clk, arst_n,
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind led_blink_pwm_controller lbpc_checker u_lbpc_checker (.*);

`default_nettype wire
